// File: hw/rtl/drs_pkg.sv
// drs_pkg: widths, result codes, shared types and the output saturation
// function of the dielectric ray scatter block
// no dependencies
package drs_pkg;

    localparam int CW    = 18;          // direction component width, signed Q2.FRAC
    localparam int FRAC  = CW - 2;
    localparam int SW    = 16;          // random sample width, unsigned Q0.SW
    localparam int IW    = 14;          // refractive index width, unsigned Q2.12
    localparam int IFRAC = 12;
    localparam int IOR_RESET = 6144;
    localparam int ONE_I = 1 << FRAC;

    localparam int UW      = FRAC + 1;              // values in [0, 1]
    localparam int ETA_W   = FRAC + 2;              // index ratio, below 4.0
    localparam int PW      = 2 * CW - FRAC;         // one dot product term
    localparam int CSUM_W  = PW + 2;
    localparam int CC_W    = FRAC + 2;              // cosine clamped to [-1, 1]
    localparam int RR_W    = CC_W + CW - FRAC;
    localparam int RF_W    = RR_W + 2;
    localparam int ED_W    = ETA_W + 1 + CW - FRAC;
    localparam int EC_W    = ETA_W;
    localparam int T1_W    = ETA_W + UW - FRAC;
    localparam int T2_W    = ETA_W + T1_W - FRAC;
    localparam int DISC_W  = T2_W + 1;
    localparam int SQ_IN_W = UW + FRAC;
    localparam int SQ_W    = SQ_IN_W + 1;
    localparam int SQ_STAGES = (SQ_IN_W + 1) / 2;
    localparam int SQRT_W  = UW;
    localparam int COEF_W  = EC_W + 2;
    localparam int NN_W    = CW + 1;
    localparam int PR_W    = COEF_W + NN_W - FRAC;
    localparam int SUM_W   = PR_W + 1;
    localparam int CMP_W   = SW + FRAC + 2;

    localparam int NUM_W = FRAC + IW;               // divider dividend
    localparam int DEN_W = IW + 1;                  // divider divisor
    localparam int QUO_W = UW;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        KIND_TIR     = 2'd0,
        KIND_FRESNEL = 2'd1,
        KIND_REFRACT = 2'd2
    } kind_t;

    // material constants, valid while the coefficient unit is not busy
    typedef struct packed {
        logic [QUO_W-1:0] recip;    // 1/ior, rounded
        logic [IW-1:0]    iorc;     // ior, at least 1.0
        logic [FRAC-1:0]  r0;       // normal-incidence reflectance
    } drs_coef_t;

    // per-ray context carried past the square root
    typedef struct packed {
        kind_t                 kind;
        logic                  ent;
        logic [2:0][CW-1:0]    n;
        logic [2:0][ED_W-1:0]  ed;
        logic [EC_W-1:0]       ec;
        logic [2:0][CW-1:0]    rf;
    } drs_ctx_t;

    function automatic logic [CW-1:0] sat_cw(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (CW - 1)) - 1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            return hi[CW-1:0];
        end
        else if (v < lo)
        begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage

// File: hw/rtl/drs_coef_gen.sv
// drs_coef_gen: refractive index register and the bit-serial divider that
// derives 1/ior and the Schlick base reflectance from it
// depends on drs_pkg
module drs_coef_gen
    import drs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [IW-1:0]   cfg_wdata,
    output logic            busy,
    output drs_coef_t       coef
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD_R = 6'b000010,
        ST_DIV_R  = 6'b000100,
        ST_LOAD_Q = 6'b001000,
        ST_DIV_Q  = 6'b010000,
        ST_SQR    = 6'b100000
    } state_t;

    localparam logic [IW-1:0] ONE_IOR = IW'(1 << IFRAC);

    state_t             state_reg, state_next;
    logic [IW-1:0]      ior_reg, ior_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [QUO_W-1:0]   recip_reg, recip_next;
    logic [FRAC-1:0]    q_reg, q_next;
    logic [FRAC-1:0]    r0_reg, r0_next;

    logic [IW-1:0]      iorc;
    logic [DEN_W:0]     trial;
    logic               ge;
    logic [2*FRAC-1:0]  qsq;

    assign iorc  = (ior_reg < ONE_IOR) ? ONE_IOR : ior_reg;
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign qsq   = q_reg * q_reg;

    always_comb
    begin
        state_next = state_reg;
        ior_next   = ior_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        recip_next = recip_reg;
        q_next     = q_reg;
        r0_next    = r0_reg;
        case (state_reg)
            ST_LOAD_R:
            begin
                num_next   = (NUM_W'(1) << (FRAC + IFRAC)) + NUM_W'(iorc >> 1);
                den_next   = DEN_W'(iorc);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV_R;
            end
            ST_DIV_R, ST_DIV_Q:
            begin
                // one quotient bit per cycle, restoring
                rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                num_next = num_reg << 1;
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    if (state_reg == ST_DIV_R)
                    begin
                        recip_next = quo_next;
                        state_next = ST_LOAD_Q;
                    end
                    else
                    begin
                        q_next     = quo_next[FRAC-1:0];
                        state_next = ST_SQR;
                    end
                end
            end
            ST_LOAD_Q:
            begin
                num_next   = NUM_W'(iorc - ONE_IOR) << FRAC;
                den_next   = DEN_W'(iorc) + DEN_W'(ONE_IOR);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV_Q;
            end
            ST_SQR:
            begin
                r0_next    = qsq[2*FRAC-1:FRAC];
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_LOAD_R;
            end
        endcase
        if (cfg_we)
        begin
            ior_next   = cfg_wdata;
            state_next = ST_LOAD_R;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD_R;
            ior_reg   <= IW'(IOR_RESET);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ior_reg   <= ior_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        recip_reg <= recip_next;
        q_reg     <= q_next;
        r0_reg    <= r0_next;
    end

    assign busy       = state_reg != ST_IDLE;
    assign coef.recip = recip_reg;
    assign coef.iorc  = iorc;
    assign coef.r0    = r0_reg;

endmodule

// File: hw/rtl/drs_front.sv
// drs_front: seven-stage pipeline from the ray inputs to the discriminant,
// the Schlick reflectance decision and the reflected direction
// depends on drs_pkg
module drs_front
    import drs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  drs_coef_t               coef,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CW-1:0]    d_x,
    input  logic signed [CW-1:0]    d_y,
    input  logic signed [CW-1:0]    d_z,
    input  logic signed [CW-1:0]    n_x,
    input  logic signed [CW-1:0]    n_y,
    input  logic signed [CW-1:0]    n_z,
    input  logic [SW-1:0]           smp,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SQ_W-1:0]         out_sqv,
    output drs_ctx_t                out_ctx
);

    localparam int NS = 7;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic signed [CW-1:0] d_in [3];
    logic signed [CW-1:0] n_in [3];

    // stage 1
    logic signed [PW-1:0]    s1_p_reg [3], s1_p_next [3];
    logic signed [CW-1:0]    s1_d_reg [3], s1_n_reg [3];
    logic [SW-1:0]           s1_smp_reg;
    // stage 2
    logic signed [CC_W-1:0]  s2_cc_reg, s2_cc_next;
    logic [UW-1:0]           s2_cosp_reg, s2_cosp_next;
    logic [UW-1:0]           s2_x_reg, s2_x_next;
    logic [ETA_W-1:0]        s2_eta_reg, s2_eta_next;
    logic                    s2_ent_reg, s2_ent_next;
    logic signed [CW-1:0]    s2_d_reg [3], s2_n_reg [3];
    logic [SW-1:0]           s2_smp_reg;
    // stage 3
    logic [UW-1:0]           s3_cos2_reg, s3_cos2_next;
    logic [UW-1:0]           s3_x2_reg, s3_x2_next;
    logic [UW-1:0]           s3_x_reg;
    logic signed [RR_W-1:0]  s3_rr_reg [3], s3_rr_next [3];
    logic signed [ED_W-1:0]  s3_ed_reg [3], s3_ed_next [3];
    logic [EC_W-1:0]         s3_ec_reg, s3_ec_next;
    logic [ETA_W-1:0]        s3_eta_reg;
    logic                    s3_ent_reg;
    logic signed [CW-1:0]    s3_d_reg [3], s3_n_reg [3];
    logic [SW-1:0]           s3_smp_reg;
    // stage 4
    logic [T1_W-1:0]         s4_t1_reg, s4_t1_next;
    logic [UW-1:0]           s4_x4_reg, s4_x4_next;
    logic [UW-1:0]           s4_x_reg;
    logic [CW-1:0]           s4_rf_reg [3], s4_rf_next [3];
    logic signed [ED_W-1:0]  s4_ed_reg [3];
    logic [EC_W-1:0]         s4_ec_reg;
    logic [ETA_W-1:0]        s4_eta_reg;
    logic                    s4_ent_reg;
    logic signed [CW-1:0]    s4_n_reg [3];
    logic [SW-1:0]           s4_smp_reg;
    // stage 5
    logic signed [DISC_W-1:0] s5_disc_reg, s5_disc_next;
    logic [UW-1:0]           s5_x5_reg, s5_x5_next;
    logic [CW-1:0]           s5_rf_reg [3];
    logic signed [ED_W-1:0]  s5_ed_reg [3];
    logic [EC_W-1:0]         s5_ec_reg;
    logic                    s5_ent_reg;
    logic signed [CW-1:0]    s5_n_reg [3];
    logic [SW-1:0]           s5_smp_reg;
    // stage 6
    logic [UW:0]             s6_refl_reg, s6_refl_next;
    logic                    s6_pos_reg, s6_pos_next;
    logic [SQ_W-1:0]         s6_sqv_reg, s6_sqv_next;
    logic [CW-1:0]           s6_rf_reg [3];
    logic signed [ED_W-1:0]  s6_ed_reg [3];
    logic [EC_W-1:0]         s6_ec_reg;
    logic                    s6_ent_reg;
    logic signed [CW-1:0]    s6_n_reg [3];
    logic [SW-1:0]           s6_smp_reg;
    // stage 7
    logic [SQ_W-1:0]         s7_sqv_reg;
    drs_ctx_t                s7_ctx_reg, s7_ctx_next;

    assign d_in[0] = d_x;
    assign d_in[1] = d_y;
    assign d_in[2] = d_z;
    assign n_in[0] = n_x;
    assign n_in[1] = n_y;
    assign n_in[2] = n_z;

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: component products of the dot product
    always_comb
    begin
        logic signed [2*CW-1:0] pr;
        for (int i = 0; i < 3; i++)
        begin
            pr = d_in[i] * n_in[i];
            s1_p_next[i] = PW'(pr >>> FRAC);
        end
    end

    // stage 2: cosine, side of the surface, index ratio
    always_comb
    begin
        logic signed [CSUM_W-1:0] c;
        c = CSUM_W'(s1_p_reg[0]) + CSUM_W'(s1_p_reg[1]) + CSUM_W'(s1_p_reg[2]);
        if (c > CSUM_W'(ONE_I))
        begin
            s2_cc_next = CC_W'(ONE_I);
        end
        else if (c < -CSUM_W'(ONE_I))
        begin
            s2_cc_next = -CC_W'(ONE_I);
        end
        else
        begin
            s2_cc_next = CC_W'(c);
        end
        s2_ent_next  = c[CSUM_W-1];
        s2_cosp_next = s2_ent_next ? UW'(-s2_cc_next) : UW'(s2_cc_next);
        s2_x_next    = UW'(ONE_I) - s2_cosp_next;
        s2_eta_next  = s2_ent_next ? ETA_W'(coef.recip)
                                   : ETA_W'(coef.iorc) << (FRAC - IFRAC);
    end

    // stage 3: squares and the first products
    always_comb
    begin
        logic [2*UW-1:0]                pc2;
        logic [2*UW-1:0]                px2;
        logic [ETA_W+UW-1:0]            pec;
        logic signed [CC_W+CW-1:0]      prr;
        logic signed [ETA_W+CW:0]       ped;
        pc2 = s2_cosp_reg * s2_cosp_reg;
        px2 = s2_x_reg * s2_x_reg;
        pec = s2_eta_reg * s2_cosp_reg;
        s3_cos2_next = UW'(pc2 >> FRAC);
        s3_x2_next   = UW'(px2 >> FRAC);
        s3_ec_next   = EC_W'(pec >> FRAC);
        for (int i = 0; i < 3; i++)
        begin
            prr = s2_cc_reg * s2_n_reg[i];
            s3_rr_next[i] = RR_W'(prr >>> FRAC);
            ped = $signed({1'b0, s2_eta_reg}) * s2_d_reg[i];
            s3_ed_next[i] = ED_W'(ped >>> FRAC);
        end
    end

    // stage 4: eta * sin^2, x^4, reflected direction
    always_comb
    begin
        logic [UW-1:0]             omc;
        logic [ETA_W+UW-1:0]       pt1;
        logic [2*UW-1:0]           px4;
        logic signed [RF_W-1:0]    rfv;
        omc = UW'(ONE_I) - s3_cos2_reg;
        pt1 = s3_eta_reg * omc;
        px4 = s3_x2_reg * s3_x2_reg;
        s4_t1_next = T1_W'(pt1 >> FRAC);
        s4_x4_next = UW'(px4 >> FRAC);
        for (int i = 0; i < 3; i++)
        begin
            rfv = RF_W'(s3_d_reg[i]) - RF_W'(s3_rr_reg[i]) - RF_W'(s3_rr_reg[i]);
            s4_rf_next[i] = sat_cw(SUM_W'(rfv));
        end
    end

    // stage 5: discriminant, x^5
    always_comb
    begin
        logic [ETA_W+T1_W-1:0]  pt2;
        logic [2*UW-1:0]        px5;
        pt2 = s4_eta_reg * s4_t1_reg;
        px5 = s4_x4_reg * s4_x_reg;
        s5_disc_next = DISC_W'(ONE_I) - DISC_W'(T2_W'(pt2 >> FRAC));
        s5_x5_next   = UW'(px5 >> FRAC);
    end

    // stage 6: Schlick reflectance, square root operand
    always_comb
    begin
        logic [UW-1:0]    omr0;
        logic [2*UW-1:0]  pm;
        omr0 = UW'(ONE_I) - UW'(coef.r0);
        pm   = omr0 * s5_x5_reg;
        s6_refl_next = (UW+1)'(coef.r0) + (UW+1)'(pm >> FRAC);
        s6_pos_next  = !s5_disc_reg[DISC_W-1] && (s5_disc_reg != '0);
        s6_sqv_next  = s6_pos_next ? (SQ_W'(s5_disc_reg[UW-1:0]) << FRAC) : '0;
    end

    // stage 7: scatter kind
    always_comb
    begin
        logic below;
        below = (CMP_W'(s6_smp_reg) << FRAC) < (CMP_W'(s6_refl_reg) << SW);
        if (!s6_pos_reg)
        begin
            s7_ctx_next.kind = KIND_TIR;
        end
        else if (below)
        begin
            s7_ctx_next.kind = KIND_FRESNEL;
        end
        else
        begin
            s7_ctx_next.kind = KIND_REFRACT;
        end
        s7_ctx_next.ent = s6_ent_reg;
        s7_ctx_next.ec  = s6_ec_reg;
        for (int i = 0; i < 3; i++)
        begin
            s7_ctx_next.n[i]  = s6_n_reg[i];
            s7_ctx_next.ed[i] = s6_ed_reg[i];
            s7_ctx_next.rf[i] = s6_rf_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_smp_reg <= smp;
            for (int i = 0; i < 3; i++)
            begin
                s1_p_reg[i] <= s1_p_next[i];
                s1_d_reg[i] <= d_in[i];
                s1_n_reg[i] <= n_in[i];
            end
        end
        if (en[1])
        begin
            s2_cc_reg   <= s2_cc_next;
            s2_cosp_reg <= s2_cosp_next;
            s2_x_reg    <= s2_x_next;
            s2_eta_reg  <= s2_eta_next;
            s2_ent_reg  <= s2_ent_next;
            s2_smp_reg  <= s1_smp_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i] <= s1_d_reg[i];
                s2_n_reg[i] <= s1_n_reg[i];
            end
        end
        if (en[2])
        begin
            s3_cos2_reg <= s3_cos2_next;
            s3_x2_reg   <= s3_x2_next;
            s3_x_reg    <= s2_x_reg;
            s3_ec_reg   <= s3_ec_next;
            s3_eta_reg  <= s2_eta_reg;
            s3_ent_reg  <= s2_ent_reg;
            s3_smp_reg  <= s2_smp_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_rr_reg[i] <= s3_rr_next[i];
                s3_ed_reg[i] <= s3_ed_next[i];
                s3_d_reg[i]  <= s2_d_reg[i];
                s3_n_reg[i]  <= s2_n_reg[i];
            end
        end
        if (en[3])
        begin
            s4_t1_reg  <= s4_t1_next;
            s4_x4_reg  <= s4_x4_next;
            s4_x_reg   <= s3_x_reg;
            s4_ec_reg  <= s3_ec_reg;
            s4_eta_reg <= s3_eta_reg;
            s4_ent_reg <= s3_ent_reg;
            s4_smp_reg <= s3_smp_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_rf_reg[i] <= s4_rf_next[i];
                s4_ed_reg[i] <= s3_ed_reg[i];
                s4_n_reg[i]  <= s3_n_reg[i];
            end
        end
        if (en[4])
        begin
            s5_disc_reg <= s5_disc_next;
            s5_x5_reg   <= s5_x5_next;
            s5_ec_reg   <= s4_ec_reg;
            s5_ent_reg  <= s4_ent_reg;
            s5_smp_reg  <= s4_smp_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_rf_reg[i] <= s4_rf_reg[i];
                s5_ed_reg[i] <= s4_ed_reg[i];
                s5_n_reg[i]  <= s4_n_reg[i];
            end
        end
        if (en[5])
        begin
            s6_refl_reg <= s6_refl_next;
            s6_pos_reg  <= s6_pos_next;
            s6_sqv_reg  <= s6_sqv_next;
            s6_ec_reg   <= s5_ec_reg;
            s6_ent_reg  <= s5_ent_reg;
            s6_smp_reg  <= s5_smp_reg;
            for (int i = 0; i < 3; i++)
            begin
                s6_rf_reg[i] <= s5_rf_reg[i];
                s6_ed_reg[i] <= s5_ed_reg[i];
                s6_n_reg[i]  <= s5_n_reg[i];
            end
        end
        if (en[6])
        begin
            s7_sqv_reg <= s6_sqv_reg;
            s7_ctx_reg <= s7_ctx_next;
        end
    end

    assign out_sqv = s7_sqv_reg;
    assign out_ctx = s7_ctx_reg;

endmodule

// File: hw/rtl/drs_sqrt.sv
// drs_sqrt: pipelined floor square root, one result bit per stage, with the
// ray context carried alongside
// depends on drs_pkg
module drs_sqrt
    import drs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SQ_W-1:0]    in_sqv,
    input  drs_ctx_t           in_ctx,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SQRT_W-1:0]  out_root,
    output drs_ctx_t           out_ctx
);

    logic [SQ_STAGES-1:0] v_reg;
    logic [SQ_STAGES-1:0] en;

    logic [SQ_W-1:0] rv_reg   [SQ_STAGES];
    logic [SQ_W-1:0] root_reg [SQ_STAGES];
    drs_ctx_t        ctx_reg  [SQ_STAGES];

    always_comb
    begin
        en[SQ_STAGES-1] = !v_reg[SQ_STAGES-1] || out_ready;
        for (int i = SQ_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[SQ_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        logic [SQ_W-1:0] rv_in;
        logic [SQ_W-1:0] root_in;
        logic [SQ_W-1:0] cand;
        logic [SQ_W-1:0] rv_next;
        logic [SQ_W-1:0] root_next;
        drs_ctx_t        ctx_in;

        if (k == 0)
        begin : g_first
            assign rv_in   = in_sqv;
            assign root_in = '0;
            assign ctx_in  = in_ctx;
        end
        else
        begin : g_rest
            assign rv_in   = rv_reg[k-1];
            assign root_in = root_reg[k-1];
            assign ctx_in  = ctx_reg[k-1];
        end

        // trial bit walks down two places per stage
        assign cand = root_in + (SQ_W'(1) << (2 * (SQ_STAGES - 1 - k)));

        always_comb
        begin
            if (rv_in >= cand)
            begin
                rv_next   = rv_in - cand;
                root_next = (root_in >> 1) + (SQ_W'(1) << (2 * (SQ_STAGES - 1 - k)));
            end
            else
            begin
                rv_next   = rv_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rv_reg[k]   <= rv_next;
                root_reg[k] <= root_next;
                ctx_reg[k]  <= ctx_in;
            end
        end
    end

    assign out_root = root_reg[SQ_STAGES-1][SQRT_W-1:0];
    assign out_ctx  = ctx_reg[SQ_STAGES-1];

endmodule

// File: hw/rtl/drs_back.sv
// drs_back: refraction coefficient, refracted direction and output register
// stage with saturation and result selection
// depends on drs_pkg
module drs_back
    import drs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SQRT_W-1:0]  in_root,
    input  drs_ctx_t           in_ctx,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CW-1:0]      res_x,
    output logic [CW-1:0]      res_y,
    output logic [CW-1:0]      res_z,
    output logic [1:0]         res_kind
);

    logic [1:0] v_reg;
    logic [1:0] en;

    logic signed [PR_W-1:0]  b1_pr_reg [3], b1_pr_next [3];
    logic signed [ED_W-1:0]  b1_ed_reg [3];
    logic [CW-1:0]           b1_rf_reg [3];
    kind_t                   b1_kind_reg;

    logic [CW-1:0]           b2_out_reg [3], b2_out_next [3];
    kind_t                   b2_kind_reg;

    assign en[1]     = !v_reg[1] || out_ready;
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // coef * normal, normal flipped on exit
    always_comb
    begin
        logic signed [COEF_W-1:0]       cf;
        logic signed [NN_W-1:0]         nn;
        logic signed [COEF_W+NN_W-1:0]  pr;
        cf = COEF_W'(in_ctx.ec) - COEF_W'(in_root);
        for (int i = 0; i < 3; i++)
        begin
            nn = NN_W'($signed(in_ctx.n[i]));
            if (!in_ctx.ent)
            begin
                nn = -nn;
            end
            pr = cf * nn;
            b1_pr_next[i] = PR_W'(pr >>> FRAC);
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            sum = SUM_W'(b1_ed_reg[i]) + SUM_W'(b1_pr_reg[i]);
            b2_out_next[i] = (b1_kind_reg == KIND_REFRACT) ? sat_cw(sum) : b1_rf_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            b1_kind_reg <= in_ctx.kind;
            for (int i = 0; i < 3; i++)
            begin
                b1_pr_reg[i] <= b1_pr_next[i];
                b1_ed_reg[i] <= $signed(in_ctx.ed[i]);
                b1_rf_reg[i] <= in_ctx.rf[i];
            end
        end
        if (en[1])
        begin
            b2_kind_reg <= b1_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                b2_out_reg[i] <= b2_out_next[i];
            end
        end
    end

    assign res_x    = b2_out_reg[0];
    assign res_y    = b2_out_reg[1];
    assign res_z    = b2_out_reg[2];
    assign res_kind = b2_kind_reg;

endmodule

// File: hw/rtl/dielectric_ray_scatter.sv
// dielectric_ray_scatter: top level of the glass surface scatter block
// depends on drs_pkg, drs_coef_gen, drs_front, drs_sqrt, drs_back
//
// channel   signals                                   transfer when
// config    cfg_we, cfg_wdata                         cfg_we high
// ray in    in_valid/in_ready, dir_*, norm_*, sample  in_valid & in_ready
// result    out_valid/out_ready, out_*, scatter_kind  out_valid & out_ready
//
// one ray per cycle while the divider is idle and no result is held; 7 front stages,
// 17 square root stages (one bit per stage) and 2 back stages
// every stage loads when empty or when its item moves on, so bubbles close up
// and a stalled result holds only the stages behind it
// after reset and after each index write the bit-serial divider runs to form
// 1/ior and the base reflectance; in_ready stays low meanwhile
module dielectric_ray_scatter
    import drs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IW-1:0]        cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    input  logic signed [CW-1:0] norm_x,
    input  logic signed [CW-1:0] norm_y,
    input  logic signed [CW-1:0] norm_z,
    input  logic [SW-1:0]        random_sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [CW-1:0] out_z,
    output logic [1:0]           scatter_kind
);

    drs_coef_t          coef;
    logic               busy;
    logic               front_ready;
    logic               f_valid, f_ready;
    logic [SQ_W-1:0]    f_sqv;
    drs_ctx_t           f_ctx;
    logic               q_valid, q_ready;
    logic [SQRT_W-1:0]  q_root;
    drs_ctx_t           q_ctx;

    drs_coef_gen u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .coef      (coef)
    );

    assign in_ready = front_ready && !busy;

    drs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (in_valid && !busy),
        .in_ready  (front_ready),
        .d_x       (dir_x),
        .d_y       (dir_y),
        .d_z       (dir_z),
        .n_x       (norm_x),
        .n_y       (norm_y),
        .n_z       (norm_z),
        .smp       (random_sample),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_sqv   (f_sqv),
        .out_ctx   (f_ctx)
    );

    drs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_sqv    (f_sqv),
        .in_ctx    (f_ctx),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_root  (q_root),
        .out_ctx   (q_ctx)
    );

    drs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_root   (q_root),
        .in_ctx    (q_ctx),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_x     (out_x),
        .res_y     (out_y),
        .res_z     (out_z),
        .res_kind  (scatter_kind)
    );

endmodule
